// ===== hw/rtl/page_frame_allocator_with_directory_defines.svh =====
// Assertion macros used by the checker file of the frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_WITH_DIRECTORY_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_WITH_DIRECTORY_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define PFAD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfad checker: same-cycle property failed");

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define PFAD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfad checker: next-cycle property failed");

`endif

// ===== hw/rtl/pfad_pkg.sv =====
package pfad_pkg;

	// Sizes of the frame pool and the directory store.
	localparam int FRAMES      = 32;
	localparam int DIRECTORIES = 16;
	localparam int ENTRIES     = 1024;

	localparam int FRAME_W       = $clog2(FRAMES);
	localparam int COUNT_W       = $clog2(FRAMES + 1);
	localparam int DIR_W         = $clog2(DIRECTORIES);
	localparam int IDX_W         = $clog2(ENTRIES);
	localparam int ADDR_W        = DIR_W + IDX_W;
	localparam int FLAGS_W       = 4;
	localparam int ENTRY_FRAME_W = 10;
	localparam int ENTRY_W       = ENTRY_FRAME_W + FLAGS_W;

	// Port field widths.
	localparam int CMD_W      = 3;
	localparam int DIR_ID_W   = 4;
	localparam int PHYS_W     = 5;
	localparam int AMOUNT_W   = 6;
	localparam int STATUS_W   = 2;
	localparam int FRAME_NO_W = 5;
	localparam int FREE_W     = 6;

	// Directory entry templates.
	localparam logic [FLAGS_W-1:0] ALLOC_FLAGS  = 4'hF;
	localparam logic [FLAGS_W-1:0] KERNEL_FLAGS = 4'hB;
	localparam logic [IDX_W-1:0]   KERNEL_LOW   = IDX_W'(0);
	localparam logic [IDX_W-1:0]   KERNEL_HIGH  = IDX_W'(10'h300);
	localparam logic [IDX_W-1:0]   LAST_INDEX   = IDX_W'(ENTRIES - 1);

	typedef enum logic [CMD_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_CHECK = 3'd2,
		OP_MAP   = 3'd3,
		OP_CLONE = 3'd4,
		OP_INIT  = 3'd5
	} pfad_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_USED    = 2'd2
	} pfad_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic sweep_en;
		logic commit;
	} pfad_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
	} pfad_stat_t;

	function automatic logic [ENTRY_W-1:0] make_entry(input logic [FLAGS_W-1:0] flags,
			input logic [ENTRY_FRAME_W-1:0] frame);
		make_entry = {frame, flags};
	endfunction

endpackage

// ===== hw/rtl/pfad_ctrl.sv =====
module pfad_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pfad_pkg::CMD_W-1:0]    cmd,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  pfad_pkg::pfad_stat_t          stat,
	output pfad_pkg::pfad_cmd_t           ctl
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WRITE = 3'b010,
		S_SWEEP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   commit;

	// The result register is free when empty or when its transfer happens now.
	assign commit   = (state_q == S_WRITE) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	assign ctl.accept   = in_valid && (state_q == S_IDLE);
	assign ctl.sweep_en = (state_q == S_SWEEP);
	assign ctl.commit   = commit;
	assign out_valid    = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == pfad_pkg::OP_INIT) ? S_SWEEP : S_WRITE;
				end
			end
			S_SWEEP: begin
				if (stat.sweep_last) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= commit || (out_valid_q && out_stall);
		end
	end

endmodule

// ===== hw/rtl/pfad_dpath.sv =====
module pfad_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfad_pkg::pfad_cmd_t              ctl,
	output pfad_pkg::pfad_stat_t             stat,
	input  logic [pfad_pkg::CMD_W-1:0]       cmd,
	input  logic [pfad_pkg::DIR_ID_W-1:0]    dir_id,
	input  logic [pfad_pkg::DIR_ID_W-1:0]    src_dir_id,
	input  logic [pfad_pkg::IDX_W-1:0]       virt_index,
	input  logic [pfad_pkg::PHYS_W-1:0]      phys_frame,
	input  logic [pfad_pkg::FLAGS_W-1:0]     entry_flags,
	input  logic [pfad_pkg::AMOUNT_W-1:0]    amount,
	output logic [pfad_pkg::STATUS_W-1:0]    status,
	output logic                             enough_free,
	output logic [pfad_pkg::FRAME_NO_W-1:0]  frame_number,
	output logic [pfad_pkg::FREE_W-1:0]      free_frames
);

	localparam int CMP_W = pfad_pkg::ENTRY_FRAME_W + 1;

	// Directory store; entries are undefined until written.
	logic [pfad_pkg::ENTRY_W-1:0] dir_mem [pfad_pkg::DIRECTORIES * pfad_pkg::ENTRIES];

	// Captured command fields.
	logic [pfad_pkg::CMD_W-1:0]    cmd_q;
	logic [pfad_pkg::DIR_W-1:0]    dir_q;
	logic [pfad_pkg::IDX_W-1:0]    vidx_q;
	logic [pfad_pkg::PHYS_W-1:0]   pframe_q;
	logic [pfad_pkg::FLAGS_W-1:0]  flags_q;
	logic [pfad_pkg::AMOUNT_W-1:0] amount_q;
	logic [pfad_pkg::ENTRY_W-1:0]  rdata_q;
	logic [pfad_pkg::IDX_W-1:0]    sweep_q;

	// Allocation state.
	logic [pfad_pkg::FRAMES-1:0]  used_q;
	logic [pfad_pkg::COUNT_W-1:0] count_q;

	// Result register.
	logic [pfad_pkg::STATUS_W-1:0]   status_q;
	logic                            enough_q;
	logic [pfad_pkg::FRAME_NO_W-1:0] frame_q;
	logic [pfad_pkg::FREE_W-1:0]     free_q;

	logic [pfad_pkg::DIR_W-1:0]         rd_dir;
	logic [pfad_pkg::ADDR_W-1:0]        rd_addr;
	logic                               free_found;
	logic [pfad_pkg::FRAME_W-1:0]       free_idx;
	logic [pfad_pkg::ENTRY_FRAME_W-1:0] rd_frame;
	logic                               rd_in_range;
	logic                               map_ok;
	logic                               cmd_we;
	logic [pfad_pkg::ENTRY_W-1:0]       cmd_wdata;
	logic [pfad_pkg::FRAMES-1:0]        used_d;
	logic [pfad_pkg::COUNT_W-1:0]       count_d;
	logic [pfad_pkg::STATUS_W-1:0]      status_d;
	logic                               enough_d;
	logic [pfad_pkg::FRAME_NO_W-1:0]    frame_d;
	logic                               mem_we;
	logic [pfad_pkg::ADDR_W-1:0]        wr_addr;
	logic [pfad_pkg::ENTRY_W-1:0]       wr_data;

	assign stat.sweep_last = (sweep_q == pfad_pkg::LAST_INDEX);

	// Clone reads the source directory, every other command the target.
	assign rd_dir  = (cmd == pfad_pkg::OP_CLONE) ? src_dir_id[pfad_pkg::DIR_W-1:0]
		: dir_id[pfad_pkg::DIR_W-1:0];
	assign rd_addr = {rd_dir, virt_index};

	// Lowest free frame, priority from frame zero.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = pfad_pkg::FRAMES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = pfad_pkg::FRAME_W'(i);
			end
		end
	end

	// Frame named by the entry read for a free; frames past the pool count as unused.
	assign rd_frame    = rdata_q[pfad_pkg::ENTRY_W-1:pfad_pkg::FLAGS_W];
	assign rd_in_range = {1'b0, rd_frame} < CMP_W'(pfad_pkg::FRAMES);

	// Map needs a frame inside the pool that is not in use.
	assign map_ok = (CMP_W'(pframe_q) < CMP_W'(pfad_pkg::FRAMES))
		&& !used_q[pframe_q[pfad_pkg::FRAME_W-1:0]];

	// Command evaluation: entry write, bitmap and count update, result fields.
	always_comb begin
		cmd_we    = 1'b0;
		cmd_wdata = '0;
		used_d    = used_q;
		count_d   = count_q;
		status_d  = pfad_pkg::ST_OK;
		enough_d  = 1'b0;
		frame_d   = '0;
		case (cmd_q)
			pfad_pkg::OP_ALLOC: begin
				if (free_found) begin
					cmd_we           = 1'b1;
					cmd_wdata        = pfad_pkg::make_entry(pfad_pkg::ALLOC_FLAGS,
						pfad_pkg::ENTRY_FRAME_W'(free_idx));
					used_d[free_idx] = 1'b1;
					count_d          = count_q - pfad_pkg::COUNT_W'(1);
					frame_d          = pfad_pkg::FRAME_NO_W'(free_idx);
				end else begin
					status_d = pfad_pkg::ST_NO_FREE;
				end
			end
			pfad_pkg::OP_FREE: begin
				cmd_we  = 1'b1;
				frame_d = rd_frame[pfad_pkg::FRAME_NO_W-1:0];
				if (rd_in_range && used_q[rd_frame[pfad_pkg::FRAME_W-1:0]]) begin
					used_d[rd_frame[pfad_pkg::FRAME_W-1:0]] = 1'b0;
					count_d = count_q + pfad_pkg::COUNT_W'(1);
				end else begin
					status_d = pfad_pkg::ST_USED;
				end
			end
			pfad_pkg::OP_CHECK: begin
				enough_d = (pfad_pkg::FREE_W'(count_q) >= amount_q);
			end
			pfad_pkg::OP_MAP: begin
				frame_d = pframe_q;
				if (map_ok) begin
					cmd_we    = 1'b1;
					cmd_wdata = pfad_pkg::make_entry(flags_q,
						pfad_pkg::ENTRY_FRAME_W'(pframe_q));
				end else begin
					status_d = pfad_pkg::ST_USED;
				end
			end
			pfad_pkg::OP_CLONE: begin
				cmd_we    = 1'b1;
				cmd_wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	// Write port: the init sweep or the committing command.
	always_comb begin
		if (ctl.sweep_en) begin
			mem_we  = 1'b1;
			wr_addr = {dir_q, sweep_q};
			wr_data = ((sweep_q == pfad_pkg::KERNEL_LOW) || (sweep_q == pfad_pkg::KERNEL_HIGH))
				? pfad_pkg::make_entry(pfad_pkg::KERNEL_FLAGS, '0) : '0;
		end else begin
			mem_we  = ctl.commit && cmd_we;
			wr_addr = {dir_q, vidx_q};
			wr_data = cmd_wdata;
		end
	end

	// Directory store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dir_mem[wr_addr] <= wr_data;
		end
		if (ctl.accept) begin
			rdata_q <= dir_mem[rd_addr];
		end
	end

	// Command capture and sweep counter.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= cmd;
			dir_q    <= dir_id[pfad_pkg::DIR_W-1:0];
			vidx_q   <= virt_index;
			pframe_q <= phys_frame;
			flags_q  <= entry_flags;
			amount_q <= amount;
			sweep_q  <= '0;
		end else if (ctl.sweep_en) begin
			sweep_q <= sweep_q + pfad_pkg::IDX_W'(1);
		end
	end

	// Frame bitmap and free count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= pfad_pkg::COUNT_W'(pfad_pkg::FRAMES);
		end else if (ctl.commit) begin
			used_q  <= used_d;
			count_q <= count_d;
		end
	end

	// Result register, loaded as the command commits.
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			status_q <= status_d;
			enough_q <= enough_d;
			frame_q  <= frame_d;
			free_q   <= pfad_pkg::FREE_W'(count_d);
		end
	end

	assign status       = status_q;
	assign enough_free  = enough_q;
	assign frame_number = frame_q;
	assign free_frames  = free_q;

endmodule

// ===== hw/rtl/page_frame_allocator_with_directory.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_stall    cmd dir_id src_dir_id virt_index phys_frame entry_flags amount
// out       out_valid / out_stall  status enough_free frame_number free_frames
//
// Every command other than init reads its directory entry in the transfer cycle; the write state
// then makes the command's entry write, if any, and loads the result register once it is free.
// Init first sweeps the directory, one directory write per entry through the single write port.
// Reset empties the frame bitmap and sets the free count to 32; directory entries hold
// nothing defined until written, and reset runs no clearing pass.
// A finished result waits in the output register while out_stall is high; the next command
// is taken meanwhile and, init's sweep apart, waits before its write until the register frees.
module page_frame_allocator_with_directory (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pfad_pkg::CMD_W-1:0]       cmd,
	input  logic [pfad_pkg::DIR_ID_W-1:0]    dir_id,
	input  logic [pfad_pkg::DIR_ID_W-1:0]    src_dir_id,
	input  logic [pfad_pkg::IDX_W-1:0]       virt_index,
	input  logic [pfad_pkg::PHYS_W-1:0]      phys_frame,
	input  logic [pfad_pkg::FLAGS_W-1:0]     entry_flags,
	input  logic [pfad_pkg::AMOUNT_W-1:0]    amount,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pfad_pkg::STATUS_W-1:0]    status,
	output logic                             enough_free,
	output logic [pfad_pkg::FRAME_NO_W-1:0]  frame_number,
	output logic [pfad_pkg::FREE_W-1:0]      free_frames
);

	pfad_pkg::pfad_cmd_t  ctl;
	pfad_pkg::pfad_stat_t stat;

	// Sequencing of each command.
	pfad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Bitmap, free count, directory store and result register.
	pfad_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.dir_id       (dir_id),
		.src_dir_id   (src_dir_id),
		.virt_index   (virt_index),
		.phys_frame   (phys_frame),
		.entry_flags  (entry_flags),
		.amount       (amount),
		.status       (status),
		.enough_free  (enough_free),
		.frame_number (frame_number),
		.free_frames  (free_frames)
	);

endmodule

// ===== hw/rtl/pfad_checker.sv =====
`include "page_frame_allocator_with_directory_defines.svh"

module pfad_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [pfad_pkg::STATUS_W-1:0]    status,
	input logic                             enough_free,
	input logic [pfad_pkg::FRAME_NO_W-1:0]  frame_number,
	input logic [pfad_pkg::FREE_W-1:0]      free_frames
);

	// A result that is not taken stays offered.
	`PFAD_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)

	// One command at a time: the cycle after a transfer in, the input is stalled.
	`PFAD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

	// The free count never exceeds the pool.
	`PFAD_ASSERT_NOW(a_count_range, out_valid,
		free_frames <= pfad_pkg::FREE_W'(pfad_pkg::FRAMES))

	// A failed allocation reports an empty pool and no frame.
	`PFAD_ASSERT_NOW(a_no_free, out_valid && (status == pfad_pkg::ST_NO_FREE),
		(free_frames == '0) && (frame_number == '0))

	// Only a successful check can report enough frames.
	`PFAD_ASSERT_NOW(a_enough_ok, out_valid && enough_free, status == pfad_pkg::ST_OK)

endmodule

bind page_frame_allocator_with_directory pfad_checker u_pfad_checker (.*);

// ===== sim/tb_page_frame_allocator_with_directory.sv =====
module tb_page_frame_allocator_with_directory;
	timeunit 1ns;
	timeprecision 1ps;

	import pfad_pkg::*;

	// The two command codes that the block must take and ignore.
	localparam logic [CMD_W-1:0] OP_RESERVED_LO = 3'd6;
	localparam logic [CMD_W-1:0] OP_RESERVED_HI = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [DIR_ID_W-1:0] dir;
		logic [DIR_ID_W-1:0] src;
		logic [IDX_W-1:0]    idx;
		logic [PHYS_W-1:0]   phys;
		logic [FLAGS_W-1:0]  flags;
		logic [AMOUNT_W-1:0] amount;
	} cmd_item_t;

	typedef struct packed {
		pfad_status_t          status;
		logic                  enough;
		logic [FRAME_NO_W-1:0] frame;
		logic [FREE_W-1:0]     free_cnt;
	} result_t;

	typedef struct packed {
		logic [DIR_ID_W-1:0] dir;
		logic [IDX_W-1:0]    idx;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = '0;
	logic [DIR_ID_W-1:0] dir_id = '0;
	logic [DIR_ID_W-1:0] src_dir_id = '0;
	logic [IDX_W-1:0] virt_index = '0;
	logic [PHYS_W-1:0] phys_frame = '0;
	logic [FLAGS_W-1:0] entry_flags = '0;
	logic [AMOUNT_W-1:0] amount = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic enough_free;
	logic [FRAME_NO_W-1:0] frame_number;
	logic [FREE_W-1:0] free_frames;

	// Mirror of the allocator state.
	bit frame_used [FRAMES];
	int frames_free = FRAMES;
	logic [ENTRY_W-1:0] dir_mem [DIRECTORIES][ENTRIES];
	bit written_map [DIRECTORIES][ENTRIES];

	result_t pending_results [$];
	slot_t live_slots [$];
	int mismatches = 0;

	// Knobs for the sender and the receiver.
	int burst_left = 0;
	bit sender_gaps = 1'b1;
	bit receiver_quiet = 1'b0;

	page_frame_allocator_with_directory dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.dir_id(dir_id),
		.src_dir_id(src_dir_id),
		.virt_index(virt_index),
		.phys_frame(phys_frame),
		.entry_flags(entry_flags),
		.amount(amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.enough_free(enough_free),
		.frame_number(frame_number),
		.free_frames(free_frames)
	);

	always #1 clk = ~clk;

	// Writes one directory entry in the mirror and remembers that it holds a value.
	function automatic void store_entry(input logic [DIR_ID_W-1:0] d,
			input logic [IDX_W-1:0] i, input logic [ENTRY_W-1:0] e);
		dir_mem[d][i] = e;
		written_map[d][i] = 1'b1;
	endfunction

	// Carries out one command on the mirror and returns the result it must produce.
	function automatic result_t apply_command(input cmd_item_t it);
		result_t r;
		int f;
		logic [ENTRY_W-1:0] e;
		logic [ENTRY_FRAME_W-1:0] ef;
		r = '0;
		r.status = ST_OK;
		case (it.cmd)
			OP_ALLOC: begin
				f = 0;
				while (f < FRAMES && frame_used[FRAME_W'(f)])
					f++;
				if (f >= FRAMES) begin
					r.status = ST_NO_FREE;
				end else begin
					store_entry(it.dir, it.idx, {ENTRY_FRAME_W'(f), ALLOC_FLAGS});
					frame_used[FRAME_W'(f)] = 1'b1;
					frames_free--;
					r.frame = FRAME_NO_W'(f);
				end
			end
			OP_FREE: begin
				e = dir_mem[it.dir][it.idx];
				ef = e[ENTRY_W-1:FLAGS_W];
				store_entry(it.dir, it.idx, '0);
				r.frame = ef[FRAME_NO_W-1:0];
				if (int'(ef) < FRAMES && frame_used[ef[FRAME_W-1:0]]) begin
					frame_used[ef[FRAME_W-1:0]] = 1'b0;
					frames_free++;
				end else begin
					r.status = ST_USED;
				end
			end
			OP_CHECK: begin
				r.enough = (frames_free >= int'(it.amount));
			end
			OP_MAP: begin
				r.frame = it.phys;
				if (int'(it.phys) >= FRAMES || frame_used[it.phys])
					r.status = ST_USED;
				else
					store_entry(it.dir, it.idx, {ENTRY_FRAME_W'(it.phys), it.flags});
			end
			OP_CLONE: begin
				store_entry(it.dir, it.idx, dir_mem[it.src][it.idx]);
			end
			OP_INIT: begin
				for (int k = 0; k < ENTRIES; k++)
					store_entry(it.dir, IDX_W'(k), '0);
				store_entry(it.dir, KERNEL_LOW, {ENTRY_FRAME_W'(0), KERNEL_FLAGS});
				store_entry(it.dir, KERNEL_HIGH, {ENTRY_FRAME_W'(0), KERNEL_FLAGS});
			end
			default: begin
			end
		endcase
		r.free_cnt = FREE_W'(frames_free);
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(input logic [CMD_W-1:0] op,
			input logic [DIR_ID_W-1:0] d, input logic [DIR_ID_W-1:0] s,
			input logic [IDX_W-1:0] i, input logic [PHYS_W-1:0] p,
			input logic [FLAGS_W-1:0] fl, input logic [AMOUNT_W-1:0] am);
		cmd_item_t it;
		it.cmd = op;
		it.dir = d;
		it.src = s;
		it.idx = i;
		it.phys = p;
		it.flags = fl;
		it.amount = am;
		return it;
	endfunction

	function automatic cmd_item_t random_fields();
		return make_cmd(CMD_W'($urandom_range(0, 7)), DIR_ID_W'($urandom_range(0, 15)),
			DIR_ID_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, ENTRIES - 1)),
			PHYS_W'($urandom_range(0, 31)), FLAGS_W'($urandom_range(0, 15)),
			AMOUNT_W'($urandom_range(0, 63)));
	endfunction

	// Finds an entry that holds a defined value, so that reading it is legal.
	function automatic bit pick_written_slot(output slot_t s);
		s.dir = DIR_ID_W'($urandom_range(0, 15));
		s.idx = IDX_W'($urandom_range(0, ENTRIES - 1));
		for (int n = 0; n < 24; n++) begin
			if (written_map[s.dir][s.idx])
				return 1'b1;
			s.dir = DIR_ID_W'($urandom_range(0, 15));
			s.idx = IDX_W'($urandom_range(0, ENTRIES - 1));
		end
		if (live_slots.size() > 0) begin
			s = live_slots[$urandom_range(0, live_slots.size() - 1)];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Mostly allocations and releases of live entries, with some noise around them.
	function automatic cmd_item_t pick_random_command();
		cmd_item_t it;
		slot_t s;
		int sel;
		int k;
		it = random_fields();
		sel = $urandom_range(0, 99);
		if (sel < 28) begin
			it.cmd = OP_ALLOC;
		end else if (sel < 52) begin
			it.cmd = OP_FREE;
			if (live_slots.size() > 0 && $urandom_range(0, 9) < 8) begin
				k = $urandom_range(0, live_slots.size() - 1);
				s = live_slots[k];
				live_slots.delete(k);
			end else if (!pick_written_slot(s)) begin
				it.cmd = OP_CHECK;
			end
			it.dir = s.dir;
			it.idx = s.idx;
		end else if (sel < 63) begin
			it.cmd = OP_CHECK;
		end else if (sel < 78) begin
			it.cmd = OP_MAP;
		end else if (sel < 93) begin
			it.cmd = OP_CLONE;
			if (pick_written_slot(s)) begin
				it.src = s.dir;
				it.idx = s.idx;
			end else begin
				it.cmd = OP_CHECK;
			end
		end else if (sel < 95) begin
			it.cmd = OP_INIT;
		end else begin
			it.cmd = ($urandom_range(0, 1) == 1) ? OP_RESERVED_HI : OP_RESERVED_LO;
		end
		return it;
	endfunction

	// Presents one command and holds it until the transfer; the sender may idle between bursts.
	task automatic send_cmd(input cmd_item_t it);
		int gap;
		result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd <= it.cmd;
		dir_id <= it.dir;
		src_dir_id <= it.src;
		virt_index <= it.idx;
		phys_frame <= it.phys;
		entry_flags <= it.flags;
		amount <= it.amount;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = apply_command(it);
		pending_results.push_back(r);
		if (it.cmd == OP_ALLOC && r.status == ST_OK)
			live_slots.push_back({it.dir, it.idx});
	endtask

	// Holds the sender off until every expected result has come back.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic test_reset_state();
		send_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 6'd0));
		send_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 6'd32));
		send_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 6'd33));
		send_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 6'd63));
	endtask

	task automatic test_directory_init();
		send_cmd(make_cmd(OP_INIT, 4'd0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_INIT, 4'd15, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(OP_INIT, 4'd7, 0, 0, 0, 0, 0));
	endtask

	// Releasing a kernel entry returns frame 0 only while frame 0 is taken.
	task automatic test_alloc_and_free();
		send_cmd(make_cmd(OP_FREE, 4'd0, 0, KERNEL_LOW, 0, 0, 0));
		send_cmd(make_cmd(OP_ALLOC, 4'd0, 0, LAST_INDEX, 0, 0, 0));
		send_cmd(make_cmd(OP_ALLOC, 4'd15, 0, KERNEL_LOW, 0, 0, 0));
		send_cmd(make_cmd(OP_FREE, 4'd0, 0, KERNEL_HIGH, 0, 0, 0));
		send_cmd(make_cmd(OP_FREE, 4'd0, 0, LAST_INDEX, 0, 0, 0));
		send_cmd(make_cmd(OP_FREE, 4'd15, 0, KERNEL_LOW, 0, 0, 0));
	endtask

	// A map onto a taken frame is refused; a successful map leaves the frame free.
	task automatic test_map();
		send_cmd(make_cmd(OP_ALLOC, 4'd7, 0, 10'd1, 0, 0, 0));
		send_cmd(make_cmd(OP_MAP, 4'd7, 0, 10'd2, 5'd0, 4'hF, 0));
		send_cmd(make_cmd(OP_MAP, 4'd7, 0, 10'd3, 5'd31, 4'hF, 0));
		send_cmd(make_cmd(OP_MAP, 4'd7, 0, 10'd4, 5'd5, 4'h0, 0));
		send_cmd(make_cmd(OP_FREE, 4'd7, 0, 10'd3, 0, 0, 0));
	endtask

	task automatic test_clone();
		send_cmd(make_cmd(OP_CLONE, 4'd3, 4'd7, 10'd1, 0, 0, 0));
		send_cmd(make_cmd(OP_FREE, 4'd3, 0, 10'd1, 0, 0, 0));
		send_cmd(make_cmd(OP_CLONE, 4'd12, 4'd15, KERNEL_HIGH, 0, 0, 0));
	endtask

	task automatic test_unused_codes();
		cmd_item_t it;
		it = random_fields();
		it.cmd = OP_RESERVED_LO;
		send_cmd(it);
		it = random_fields();
		it.cmd = OP_RESERVED_HI;
		send_cmd(it);
	endtask

	// Fills the pool, runs into the empty case, then hands every frame back.
	task automatic test_pool_exhaustion(input int rounds);
		cmd_item_t it;
		for (int r = 0; r < rounds; r++) begin
			while (frames_free > 0) begin
				it = random_fields();
				it.cmd = OP_ALLOC;
				send_cmd(it);
			end
			repeat (3) begin
				it = random_fields();
				it.cmd = OP_ALLOC;
				send_cmd(it);
			end
			send_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 6'd0));
			send_cmd(make_cmd(OP_CHECK, 0, 0, 0, 0, 0, 6'd1));
			wait_all_results();
			while (live_slots.size() > 0) begin
				it = random_fields();
				it.cmd = OP_FREE;
				{it.dir, it.idx} = live_slots.pop_front();
				send_cmd(it);
			end
		end
	endtask

	task automatic test_random_mix(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 149)
				wait_all_results();
			send_cmd(pick_random_command());
		end
	endtask

	// Back-to-back transfers with neither side idling.
	task automatic test_back_to_back(input int count);
		wait_all_results();
		sender_gaps = 1'b0;
		receiver_quiet = 1'b1;
		for (int n = 0; n < count; n++)
			send_cmd(pick_random_command());
		wait_all_results();
		sender_gaps = 1'b1;
		receiver_quiet = 1'b0;
	endtask

	// Receiver stall pattern, in one of four modes picked anew at random.
	int recv_phase = 0;
	int recv_mode = 0;
	int stall_run = 0;
	always @(posedge clk) begin
		recv_phase <= recv_phase + 1;
		if (recv_phase % 300 == 0)
			recv_mode <= $urandom_range(0, 3);
		if (receiver_quiet || recv_mode == 0) begin
			out_stall <= 1'b0;
		end else if (recv_mode == 1) begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end else if (recv_mode == 2) begin
			if (stall_run > 0) begin
				stall_run <= stall_run - 1;
			end else begin
				out_stall <= ~out_stall;
				stall_run <= out_stall ? $urandom_range(0, 8) : $urandom_range(1, 20);
			end
		end else begin
			out_stall <= (recv_phase % 2 == 0);
		end
	end

	// Each result transfer is compared with the oldest expected result.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: status %0d frame %0d free %0d",
						status, frame_number, free_frames);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || enough_free !== want.enough ||
						frame_number !== want.frame || free_frames !== want.free_cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at %0t: status %0d/%0d enough_free %0b/%0b ",
							"frame_number %0d/%0d free_frames %0d/%0d (expected/actual)"},
							$realtime, want.status, status, want.enough, enough_free,
							want.frame, frame_number, want.free_cnt, free_frames);
				end
			end
		end
	end

	initial begin : run_tests
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directory_init();
		test_alloc_and_free();
		test_map();
		test_clone();
		test_unused_codes();
		wait_all_results();
		test_pool_exhaustion(3);
		test_random_mix(800);
		test_back_to_back(220);
		in_valid <= 1'b0;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while (pending_results.size() != 0 && n < 20000);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Guard against a hang.
	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
